// ----- rtl/text_console_writer_assert.svh -----
// ----------------------------------------------------------------------------
// text_console_writer_assert.svh
// assertion shorthands for the console writer checker
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// same-cycle implication, off during reset
`define TCW_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define TCW_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, also checked through reset
`define TCW_CHECK_NEXT_ALWAYS(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/tcw_pkg.sv -----
// ----------------------------------------------------------------------------
// tcw_pkg
// types and constants shared by the text console writer
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;
    localparam int CELL_W      = 16;

    localparam logic [1:0] FUNC_PUT     = 2'd0;
    localparam logic [1:0] FUNC_RECOLOR = 2'd1;
    localparam logic [1:0] FUNC_READ    = 2'd2;

    localparam logic [7:0]        NEWLINE_CODE = 8'h0A;
    localparam logic [7:0]        PUT_ATTR     = 8'h0F;
    localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0F20;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  char_code;
        logic [3:0]  background;
        logic [10:0] cell_index;
    } t_in;

    typedef struct packed {
        logic [15:0] cell_value;
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_column;
    } t_out;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SHIFT,
        ST_SHIFT_END,
        ST_BLANK,
        ST_PUT,
        ST_RECOLOR,
        ST_RECOLOR_END,
        ST_READ_DATA,
        ST_DONE
    } t_state;

endpackage

// ----- rtl/text_console_writer.sv -----
// ----------------------------------------------------------------------------
// text_console_writer
// text-mode console over a rows x columns store of 16-bit cells
// ----------------------------------------------------------------------------
// input channel i_in_valid / o_in_ready carries one operation per transaction:
// put character, recolor background of every cell (foreground cleared), or read one cell.
// output channel o_out_valid / i_out_ready returns one result per operation:
// the cell value for a read (zero otherwise) and the cursor after the operation.
// one operation is in flight at a time; the cell store is a single-port-write,
// registered-read memory and sets the timing.
// put of a plain character, newline without scroll, read, unused code:
//   a single finishing state (put, read data or done) hands over the result.
// recolor: a pass over every cell, one read-modify-write per cell.
// put that scrolls: row copy, then blank bottom row, then the character
//   is written (a newline writes none).
// after reset the store is cleared to zero, one cell per cycle, over all
// ROWS*COLUMNS cells; o_in_ready stays low meanwhile.
// an output register holds a finished result while the receiver stalls; the
// next operation is still taken and waits for that register to free up.
// ----------------------------------------------------------------------------
module text_console_writer #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  tcw_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output tcw_pkg::t_out o_out_data
);
    import tcw_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [CELL_W-1:0] wr_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [CELL_W-1:0] rd_data;
    logic              done;
    t_out              result;
    logic              out_free;

    logic r_out_valid;
    t_out r_out_data;

    assign out_free = !r_out_valid || i_out_ready;

    tcw_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_out_free (out_free),
        .o_done     (done),
        .o_result   (result),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .i_rd_data  (rd_data)
    );

    tcw_ram #(
        .DEPTH (CELLS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_out_data <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ----- rtl/tcw_ram.sv -----
// ----------------------------------------------------------------------------
// tcw_ram
// screen cell store, one write port and one registered read port
// ----------------------------------------------------------------------------
module tcw_ram #(
    parameter int   DEPTH = 2000,
    localparam int  AW    = $clog2(DEPTH)
) (
    input  logic                      i_clk,
    input  logic                      i_wr_en,
    input  logic [AW-1:0]             i_wr_addr,
    input  logic [tcw_pkg::CELL_W-1:0] i_wr_data,
    input  logic                      i_rd_en,
    input  logic [AW-1:0]             i_rd_addr,
    output logic [tcw_pkg::CELL_W-1:0] o_rd_data
);
    import tcw_pkg::*;

    logic [CELL_W-1:0] r_mem [DEPTH];
    logic [CELL_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/tcw_ctrl.sv -----
// ----------------------------------------------------------------------------
// tcw_ctrl
// cursor, operation sequencer and read-modify-write address generation
// ----------------------------------------------------------------------------
module tcw_ctrl #(
    parameter int  COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int  ROWS    = tcw_pkg::ROWS_DEF,
    localparam int CELLS   = ROWS * COLUMNS,
    localparam int AW      = $clog2(CELLS)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  tcw_pkg::t_in               i_in_data,
    input  logic                       i_out_free,
    output logic                       o_done,
    output tcw_pkg::t_out              o_result,
    output logic                       o_wr_en,
    output logic [AW-1:0]              o_wr_addr,
    output logic [tcw_pkg::CELL_W-1:0] o_wr_data,
    output logic                       o_rd_en,
    output logic [AW-1:0]              o_rd_addr,
    input  logic [tcw_pkg::CELL_W-1:0] i_rd_data
);
    import tcw_pkg::*;

    localparam int RW = $clog2(ROWS);
    localparam int CW = $clog2(COLUMNS + 1);
    localparam int XW = AW + 11;

    localparam logic [AW-1:0] COLS_A     = AW'(COLUMNS);
    localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);
    localparam logic [AW-1:0] LAST_SHIFT = AW'(CELLS - COLUMNS - 1);
    localparam logic [RW-1:0] LAST_ROW   = RW'(ROWS - 1);
    localparam logic [CW-1:0] COL_END    = CW'(COLUMNS);
    localparam logic [XW-1:0] CELLS_X    = XW'(CELLS);

    t_state            r_state, n_state;
    logic [RW-1:0]     r_row, n_row;
    logic [CW-1:0]     r_col, n_col;
    logic [AW-1:0]     r_idx, n_idx;
    logic              r_pipe_vld;
    logic [AW-1:0]     r_pipe_addr;
    logic [3:0]        r_bg, n_bg;
    logic [7:0]        r_code, n_code;
    logic              r_put_pend, n_put_pend;
    logic [CELL_W-1:0] r_value, n_value;

    logic              accept;
    logic              is_nl;
    logic              wrap;
    logic              adv;
    logic              last_row;
    logic              scroll;
    logic [XW-1:0]     idx_ext;
    logic              idx_ok;
    logic              finish;
    logic [RW+4:0]     row_ext;
    logic [CW+6:0]     col_ext;

    assign accept   = (r_state == ST_IDLE) && i_in_valid;
    assign is_nl    = (i_in_data.char_code == NEWLINE_CODE);
    assign wrap     = (r_col == COL_END);
    assign adv      = is_nl || wrap;
    assign last_row = (r_row == LAST_ROW);
    assign scroll   = adv && last_row;
    assign idx_ext  = {AW'(0), i_in_data.cell_index};
    assign idx_ok   = (idx_ext < CELLS_X);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_idx == LAST_CELL) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_in_data.func)
                        FUNC_PUT: begin
                            if (scroll)      n_state = ST_SHIFT;
                            else if (!is_nl) n_state = ST_PUT;
                            else             n_state = ST_DONE;
                        end
                        FUNC_RECOLOR: n_state = ST_RECOLOR;
                        FUNC_READ:    n_state = idx_ok ? ST_READ_DATA : ST_DONE;
                        default:      n_state = ST_DONE;
                    endcase
                end
            end
            ST_SHIFT: begin
                if (r_idx == LAST_SHIFT) n_state = ST_SHIFT_END;
            end
            ST_SHIFT_END: n_state = ST_BLANK;
            ST_BLANK: begin
                if (r_idx == LAST_CELL) n_state = r_put_pend ? ST_PUT : ST_DONE;
            end
            ST_RECOLOR: begin
                if (r_idx == LAST_CELL) n_state = ST_RECOLOR_END;
            end
            ST_RECOLOR_END: n_state = ST_DONE;
            ST_PUT, ST_READ_DATA, ST_DONE: begin
                n_state = i_out_free ? ST_IDLE : ST_DONE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // outputs and memory ports
    always_comb begin
        o_in_ready = (r_state == ST_IDLE);
        o_wr_en    = 1'b0;
        o_wr_addr  = r_idx;
        o_wr_data  = '0;
        o_rd_en    = 1'b0;
        o_rd_addr  = r_idx;
        unique case (r_state)
            ST_CLEAR: begin
                o_wr_en = 1'b1;
            end
            ST_IDLE: begin
                o_rd_en   = accept && (i_in_data.func == FUNC_READ) && idx_ok;
                o_rd_addr = idx_ext[AW-1:0];
            end
            ST_SHIFT, ST_SHIFT_END: begin
                o_rd_en   = (r_state == ST_SHIFT);
                o_rd_addr = r_idx + COLS_A;
                o_wr_en   = r_pipe_vld;
                o_wr_addr = r_pipe_addr;
                o_wr_data = i_rd_data;
            end
            ST_RECOLOR, ST_RECOLOR_END: begin
                o_rd_en   = (r_state == ST_RECOLOR);
                o_wr_en   = r_pipe_vld;
                o_wr_addr = r_pipe_addr;
                o_wr_data = {r_bg, 4'h0, i_rd_data[7:0]};
            end
            ST_BLANK: begin
                o_wr_en   = 1'b1;
                o_wr_data = BLANK_CELL;
            end
            ST_PUT: begin
                o_wr_en   = 1'b1;
                o_wr_addr = AW'(r_row) * COLS_A + AW'(r_col) - AW'(1);
                o_wr_data = {PUT_ATTR, r_code};
            end
            ST_READ_DATA, ST_DONE: begin
                o_wr_en = 1'b0;
            end
            default: begin
                o_wr_en = 1'b0;
            end
        endcase
    end

    assign finish   = ((r_state == ST_PUT) || (r_state == ST_READ_DATA) ||
                       (r_state == ST_DONE)) && i_out_free;
    assign row_ext  = {5'b0, r_row};
    assign col_ext  = {7'b0, r_col};
    assign o_done   = finish;
    assign o_result = '{cell_value:    (r_state == ST_READ_DATA) ? i_rd_data : r_value,
                        cursor_row:    row_ext[4:0],
                        cursor_column: col_ext[6:0]};

    // cursor and working registers
    always_comb begin
        n_row      = r_row;
        n_col      = r_col;
        n_idx      = r_idx;
        n_bg       = r_bg;
        n_code     = r_code;
        n_put_pend = r_put_pend;
        n_value    = r_value;
        if (accept) begin
            n_idx      = '0;
            n_bg       = i_in_data.background;
            n_code     = i_in_data.char_code;
            n_value    = '0;
            n_put_pend = !is_nl;
            if (i_in_data.func == FUNC_PUT) begin
                if (adv && !last_row) n_row = r_row + RW'(1);
                if (is_nl)            n_col = '0;
                else if (adv)         n_col = CW'(1);
                else                  n_col = r_col + CW'(1);
            end
        end else if ((r_state == ST_CLEAR) || (r_state == ST_SHIFT) ||
                     (r_state == ST_BLANK) || (r_state == ST_RECOLOR)) begin
            n_idx = r_idx + AW'(1);
        end
        if (r_state == ST_READ_DATA) n_value = i_rd_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_row      <= '0;
            r_col      <= '0;
            r_idx      <= '0;
            r_pipe_vld <= 1'b0;
            r_put_pend <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_row      <= n_row;
            r_col      <= n_col;
            r_idx      <= n_idx;
            r_pipe_vld <= (r_state == ST_SHIFT) || (r_state == ST_RECOLOR);
            r_put_pend <= n_put_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pipe_addr <= r_idx;
        r_bg        <= n_bg;
        r_code      <= n_code;
        r_value     <= n_value;
    end

endmodule

// ----- rtl/text_console_writer_chk.sv -----
// ----------------------------------------------------------------------------
// text_console_writer_chk
// port-level checks for the text console writer, bound to the top level
// ----------------------------------------------------------------------------
`include "text_console_writer_assert.svh"

module text_console_writer_chk #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_ready,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input tcw_pkg::t_out o_out_data
);
    import tcw_pkg::*;

    // stalled result holds
    `TCW_CHECK_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data), "result dropped or changed while stalled")

    // clearing pass follows reset
    `TCW_CHECK_NEXT_ALWAYS(a_reset_clear, !i_rst_n, !o_in_ready && !o_out_valid, "block ready or valid right after reset")

    // one transaction at a time
    `TCW_CHECK_NEXT(a_one_busy, i_in_valid && o_in_ready, !o_in_ready, "second transaction taken back to back")

    // cursor column never past the wrap position
    `TCW_CHECK(a_col_range, o_out_valid, (COLUMNS > 127) || (int'(o_out_data.cursor_column) <= COLUMNS), "cursor column out of range")

    // cursor row never past the last row
    `TCW_CHECK(a_row_range, o_out_valid, (ROWS > 32) || (int'(o_out_data.cursor_row) < ROWS), "cursor row out of range")

endmodule

bind text_console_writer text_console_writer_chk #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_chk (.*);
